// ===== hw/rtl/ring_stream_allocator_core_defines.svh =====
// assertion macros for the ring stream allocator
// used by ring_stream_allocator_core; no other dependencies
`ifndef RING_STREAM_ALLOCATOR_CORE_DEFINES_SVH
`define RING_STREAM_ALLOCATOR_CORE_DEFINES_SVH

// property checked at every clock edge outside reset
`define RSA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked at every clock edge outside reset
`define RSA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rsa_pkg.sv =====
// shared types and constants of the ring stream allocator
// no dependencies
package rsa_pkg;

	localparam int WATCH_ENTRIES_DEF = 256;

	localparam int SIZE_W  = 32;
	localparam int ALIGN_W = 17;
	localparam int TICK_W  = 32;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_MAP     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COMMIT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_TOO_BIG  = 2'd1;
	localparam logic [STAT_W-1:0] ST_BUSY     = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATOM_BYTES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ATOM_ROUND   = 2'd2;

	// reset values of the registers
	localparam logic [31:0] BUFFER_BYTES_RST = 32'd67108864;
	localparam logic [16:0] ATOM_BYTES_RST   = 17'd64;

endpackage

// ===== hw/rtl/rsa_req_if.sv =====
// request channel of the ring stream allocator
// depends on rsa_pkg
interface rsa_req_if;
	import rsa_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [SIZE_W-1:0]    request_size;
	logic [ALIGN_W-1:0]   request_alignment;
	logic                 may_wait;
	logic [TICK_W-1:0]    current_tick;
	logic [TICK_W-1:0]    completed_tick;
	modport source(output valid, command, request_size, request_alignment, may_wait,
		current_tick, completed_tick, input ready);
	modport sink(input valid, command, request_size, request_alignment, may_wait,
		current_tick, completed_tick, output ready);
endinterface

// ===== hw/rtl/rsa_rsp_if.sv =====
// response channel of the ring stream allocator
// depends on rsa_pkg
interface rsa_rsp_if;
	import rsa_pkg::*;
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [SIZE_W-1:0]   region_offset;
	logic                wait_needed;
	logic [TICK_W-1:0]   wait_tick;
	modport source(output valid, status, region_offset, wait_needed, wait_tick, input ready);
	modport sink(input valid, status, region_offset, wait_needed, wait_tick, output ready);
endinterface

// ===== hw/rtl/rsa_cfg_if.sv =====
// configuration write channel of the ring stream allocator
// depends on rsa_pkg
interface rsa_cfg_if;
	import rsa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ring_stream_allocator_core.sv =====
// Ring stream allocator: takes map, commit and reserve requests one at a time and
// answers each with one response beat. All size, alignment and offset rounding, and
// each Euclid step of the gcd used for the lcm of alignment and atom, go through one
// shared restoring divider; the walk over the previous lap's watches reads them one
// at a time through the single memory read port. A commit goes straight to the
// advance step; a map or reserve checks its size, rounds its offset to a nonzero
// alignment and walks the watches, and with atom rounding it first rounds its size
// and runs the gcd steps. The watch memory needs no clearing pass.
// depends on rsa_pkg, the three channel interfaces and the assertion macro header
`include "ring_stream_allocator_core_defines.svh"

module ring_stream_allocator_core #(
	parameter int WATCH_ENTRIES = rsa_pkg::WATCH_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rsa_req_if.sink    req,
	rsa_rsp_if.source  rsp,
	rsa_cfg_if.sink    cfg
);
	import rsa_pkg::*;

	localparam int CW = $clog2(WATCH_ENTRIES + 1);
	localparam int IW = $clog2(WATCH_ENTRIES);
	localparam int AW = $clog2(2 * WATCH_ENTRIES);
	localparam int DW = 35;
	localparam int NW = $clog2(DW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_SIZE_RND, S_GCD, S_LCM_Q, S_LCM_MUL, S_CHECK,
		S_OFF_RND, S_PLACE, S_WALK, S_WALK_CHK, S_ADV, S_DONE
	} state_t;

	state_t state_q, div_ret_q;

	// configuration
	logic [31:0] buffer_bytes_q;
	logic [16:0] atom_bytes_q;
	logic        atom_round_q;

	// allocator state
	logic [31:0]   write_offset_q, prepared_size_q;
	logic          bank_q, mark_valid_q;
	logic [CW-1:0] watch_count_q, mark_count_q, cursor_q;
	logic [31:0]   reuse_bound_q, last_tick_q;

	// latched request
	logic [CMD_W-1:0] cmd_q;
	logic             may_q;
	logic [31:0]      cur_tick_q, done_tick_q;
	logic [DW-1:0]    size_q, align_q, off_q, end_q, gcd_b_q;
	logic [16:0]      atom_q;

	// result
	logic [STAT_W-1:0] res_status_q;
	logic [31:0]       res_region_q, res_tick_q;
	logic              res_wait_q;

	// shared divider
	logic [DW-1:0] div_rem_q, div_quo_q, div_d_q;
	logic [NW-1:0] div_cnt_q;
	logic [DW+1:0] div_trial;
	logic [DW-1:0] div_rem_nx;
	logic [33:0]   lcm_prod;

	// watch memory
	logic [63:0]   watch_mem [2*WATCH_ENTRIES];
	logic [63:0]   rd_data_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [63:0]   wr_data;
	logic          wr_en;
	logic [CW-1:0] wr_slot;
	logic          merge;
	logic [31:0]   adv_sum, merge_tick;
	logic [32:0]   adv_wide;

	// output register
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [31:0]       out_region_q, out_tick_q;
	logic              out_wait_q;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.region_offset = out_region_q;
	assign rsp.wait_needed = out_wait_q;
	assign rsp.wait_tick = out_tick_q;

	// one restoring step of the divider
	always_comb begin
		div_trial = {1'b0, div_rem_q, div_quo_q[DW-1]} - {2'b00, div_d_q};
		if (div_trial[DW+1])
			div_rem_nx = {div_rem_q[DW-2:0], div_quo_q[DW-1]};
		else
			div_rem_nx = div_trial[DW-1:0];
	end

	// lcm product, both factors fit 17 bits
	assign lcm_prod = {17'd0, align_q[16:0]} * {17'd0, atom_q};

	// advance: saturating sum and watch update
	always_comb begin
		adv_wide = {1'b0, write_offset_q} + {1'b0, prepared_size_q};
		adv_sum = adv_wide[32] ? 32'hFFFF_FFFF : adv_wide[31:0];
		merge = (watch_count_q != '0) &&
			((last_tick_q == cur_tick_q) || (watch_count_q >= CW'(WATCH_ENTRIES)));
		merge_tick = (last_tick_q > cur_tick_q) ? last_tick_q : cur_tick_q;
		wr_slot = merge ? (watch_count_q - CW'(1)) : watch_count_q;
		wr_addr = AW'(wr_slot[IW-1:0]) + (bank_q ? AW'(WATCH_ENTRIES) : AW'(0));
		wr_data = {(merge ? merge_tick : cur_tick_q), adv_sum};
		wr_en = (state_q == S_ADV);
		rd_addr = AW'(cursor_q[IW-1:0]) + (bank_q ? AW'(0) : AW'(WATCH_ENTRIES));
	end

	// watch memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			watch_mem[wr_addr] <= wr_data;
		rd_data_q <= watch_mem[rd_addr];
	end

	// sequencer, divider, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_ret_q <= S_IDLE;
			buffer_bytes_q <= BUFFER_BYTES_RST;
			atom_bytes_q <= ATOM_BYTES_RST;
			atom_round_q <= 1'b0;
			write_offset_q <= '0;
			prepared_size_q <= '0;
			bank_q <= 1'b0;
			mark_valid_q <= 1'b0;
			watch_count_q <= '0;
			mark_count_q <= '0;
			cursor_q <= '0;
			reuse_bound_q <= '0;
			last_tick_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// response taken and no new beat loaded
			if (out_valid_q && rsp.ready && (state_q != S_DONE))
				out_valid_q <= 1'b0;

			// register writes
			if (cfg.valid) begin
				case (cfg.index)
					CFG_BUFFER_BYTES: buffer_bytes_q <= cfg.data;
					CFG_ATOM_BYTES:   atom_bytes_q <= cfg.data[16:0];
					CFG_ATOM_ROUND:   atom_round_q <= cfg.data[0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q <= req.command;
						may_q <= req.may_wait;
						cur_tick_q <= req.current_tick;
						done_tick_q <= req.completed_tick;
						size_q <= DW'(req.request_size);
						align_q <= DW'(req.request_alignment);
						atom_q <= (atom_bytes_q == '0) ? 17'd1 : atom_bytes_q;
						res_status_q <= ST_OK;
						res_region_q <= '0;
						res_wait_q <= 1'b0;
						res_tick_q <= '0;
						case (req.command)
							CMD_COMMIT: state_q <= S_ADV;
							CMD_MAP, CMD_RESERVE: begin
								if (atom_round_q) begin
									div_rem_q <= '0;
									div_quo_q <= DW'(req.request_size);
									div_d_q <= DW'((atom_bytes_q == '0) ? 17'd1 : atom_bytes_q);
									div_cnt_q <= NW'(DW);
									div_ret_q <= S_SIZE_RND;
									state_q <= S_DIV;
								end else begin
									state_q <= S_CHECK;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				// shared divider, one quotient bit a cycle
				S_DIV: begin
					div_rem_q <= div_rem_nx;
					div_quo_q <= {div_quo_q[DW-2:0], ~div_trial[DW+1]};
					div_cnt_q <= div_cnt_q - NW'(1);
					if (div_cnt_q == NW'(1))
						state_q <= div_ret_q;
				end
				// size rounded up to the atom, then gcd of alignment and atom (the atom alone when alignment is zero)
				S_SIZE_RND: begin
					if (div_rem_q != '0)
						size_q <= size_q - div_rem_q + DW'(atom_q);
					if (align_q != '0) begin
						gcd_b_q <= DW'(atom_q);
						div_rem_q <= '0;
						div_quo_q <= align_q;
						div_d_q <= DW'(atom_q);
						div_cnt_q <= NW'(DW);
						div_ret_q <= S_GCD;
						state_q <= S_DIV;
					end else begin
						align_q <= DW'(atom_q);
						state_q <= S_CHECK;
					end
				end
				// euclid step: (a, b) becomes (b, a mod b)
				S_GCD: begin
					gcd_b_q <= div_rem_q;
					div_rem_q <= '0;
					div_cnt_q <= NW'(DW);
					state_q <= S_DIV;
					if (div_rem_q == '0) begin
						div_quo_q <= align_q;
						div_d_q <= gcd_b_q;
						div_ret_q <= S_LCM_Q;
					end else begin
						div_quo_q <= gcd_b_q;
						div_d_q <= div_rem_q;
						div_ret_q <= S_GCD;
					end
				end
				S_LCM_Q: begin
					align_q <= div_quo_q;
					state_q <= S_LCM_MUL;
				end
				// lcm = (align / gcd) * atom
				S_LCM_MUL: begin
					align_q <= DW'(lcm_prod);
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (size_q > DW'(buffer_bytes_q)) begin
						res_status_q <= ST_TOO_BIG;
						state_q <= S_DONE;
					end else if (align_q != '0) begin
						div_rem_q <= '0;
						div_quo_q <= DW'(write_offset_q);
						div_d_q <= align_q;
						div_cnt_q <= NW'(DW);
						div_ret_q <= S_OFF_RND;
						state_q <= S_DIV;
					end else begin
						off_q <= DW'(write_offset_q);
						state_q <= S_PLACE;
					end
				end
				S_OFF_RND: begin
					off_q <= (div_rem_q == '0) ? DW'(write_offset_q) :
						DW'(write_offset_q) - div_rem_q + align_q;
					state_q <= S_PLACE;
				end
				// fit or wrap to zero with a bank swap
				S_PLACE: begin
					if (off_q + size_q > DW'(buffer_bytes_q)) begin
						mark_valid_q <= 1'b1;
						mark_count_q <= watch_count_q;
						watch_count_q <= '0;
						bank_q <= ~bank_q;
						cursor_q <= '0;
						reuse_bound_q <= '0;
						write_offset_q <= '0;
						end_q <= size_q;
					end else begin
						write_offset_q <= off_q[31:0];
						end_q <= off_q + size_q;
					end
					state_q <= S_WALK;
				end
				// walk previous lap watches below the region end
				S_WALK: begin
					if (mark_valid_q && (end_q > DW'(reuse_bound_q)) &&
						(cursor_q < mark_count_q)) begin
						state_q <= S_WALK_CHK;
					end else begin
						prepared_size_q <= size_q[31:0];
						res_region_q <= write_offset_q;
						state_q <= (cmd_q == CMD_RESERVE) ? S_ADV : S_DONE;
					end
				end
				S_WALK_CHK: begin
					if (rd_data_q[63:32] > done_tick_q) begin
						if (!may_q) begin
							res_status_q <= ST_BUSY;
							res_wait_q <= 1'b0;
							res_tick_q <= '0;
						end else begin
							res_wait_q <= 1'b1;
							if (rd_data_q[63:32] > res_tick_q)
								res_tick_q <= rd_data_q[63:32];
						end
					end
					if ((rd_data_q[63:32] > done_tick_q) && !may_q) begin
						state_q <= S_DONE;
					end else begin
						reuse_bound_q <= rd_data_q[31:0];
						cursor_q <= cursor_q + CW'(1);
						state_q <= S_WALK;
					end
				end
				// advance past the prepared region and record the watch
				S_ADV: begin
					res_region_q <= write_offset_q;
					write_offset_q <= adv_sum;
					last_tick_q <= merge ? merge_tick : cur_tick_q;
					if (!merge)
						watch_count_q <= watch_count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_region_q <= res_region_q;
						out_wait_q <= res_wait_q;
						out_tick_q <= res_tick_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RSA_ASSERT(a_count_bound, watch_count_q <= CW'(WATCH_ENTRIES), "watch count past table size")
	`RSA_ASSERT_IMP(a_cursor_bound, mark_valid_q, cursor_q <= mark_count_q, "walk cursor past lap")
	`RSA_ASSERT_IMP(a_wait_ok, out_valid_q && out_wait_q, out_status_q == ST_OK, "wait on failed beat")
	`RSA_ASSERT_IMP(a_busy_walk, state_q == S_WALK_CHK, mark_valid_q, "walk without previous lap")

endmodule
